// ----- rtl/lfha_pkg.sv -----
// Package for the lowest-free handle allocator: request/result types, codes and defaults.
`timescale 1ns / 1ps

package lfha_pkg;

  // Default sizing
  localparam int PROCESS_ENTRIES_DEF   = 8;
  localparam int SLOTS_PER_PROCESS_DEF = 64;
  localparam int FIRST_HANDLE_DEF      = 3;

  // Log2 of the widest occupancy row that the free-slot search handles in one cycle
  localparam int ROW_BITS_MAX = 5;

  typedef enum logic [0:0] {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_FOUND  = 2'd1,
    STATUS_BAD_PARAMS = 2'd2,
    STATUS_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENTRY,
    S_ROW,
    S_DONE
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [15:0] process_id;
    logic [15:0] fs_id;
    logic [15:0] handle;
  } req_t;

  typedef struct packed {
    logic [6:0] new_handle;
    status_t    status;
  } rsp_t;

endpackage

// ----- rtl/lowest_free_handle_allocator.sv -----
// Top level of the lowest-free handle allocator: request sequencer and result register.
`timescale 1ns / 1ps

// Channel   Ports                 Direction  Transfer
// request   start, busy, in_req   in         start high while busy low
// result    out_valid, out_rsp    out        one cycle strobe, always taken
//
// After reset the occupancy map is swept one row a cycle over all
// 2**(entry bits + row bits) rows (16 with the defaults); busy stays high.
// Before the next accept a request reads k entries until the process entry
// is found or claimed, then searches r occupancy rows.
// Entry lookup reads one entry a cycle; the free-slot search covers one row
// of up to 32 slots a cycle. Early rejects skip the lookup and go to the result.
// The result strobe is high exactly one cycle; the receiver cannot stall it.

module lowest_free_handle_allocator #(
  parameter int PROCESS_ENTRIES   = lfha_pkg::PROCESS_ENTRIES_DEF,
  parameter int SLOTS_PER_PROCESS = lfha_pkg::SLOTS_PER_PROCESS_DEF,
  parameter int FIRST_HANDLE      = lfha_pkg::FIRST_HANDLE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  lfha_pkg::req_t in_req,
  output logic           out_valid,
  output lfha_pkg::rsp_t out_rsp
);

  // Slot and row geometry
  localparam int SW        = $clog2(SLOTS_PER_PROCESS);
  localparam int CW        = (SW < lfha_pkg::ROW_BITS_MAX) ? SW : lfha_pkg::ROW_BITS_MAX;
  localparam int ROW_W     = 2 ** CW;
  localparam int ROWS      = (SLOTS_PER_PROCESS + ROW_W - 1) / ROW_W;
  localparam int RB        = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int EW        = (PROCESS_ENTRIES > 1) ? $clog2(PROCESS_ENTRIES) : 1;
  localparam int AW        = EW + RB;
  localparam int LAST_BITS = SLOTS_PER_PROCESS - (ROWS - 1) * ROW_W;
  localparam longint unsigned LAST_ONES = (64'd1 << LAST_BITS) - 64'd1;
  localparam logic [ROW_W-1:0] PAD_MASK = ~ROW_W'(LAST_ONES);
  localparam logic [EW-1:0] LAST_ENTRY  = EW'(PROCESS_ENTRIES - 1);
  localparam logic [RB-1:0] LAST_ROW    = RB'(ROWS - 1);

  lfha_pkg::state_t state_r, state_nxt;

  // Request registers
  lfha_pkg::op_t op_r, op_nxt;
  logic [15:0]   pid_r, pid_nxt;
  logic          bad_h_r, bad_h_nxt;
  logic [SW-1:0] slot_r, slot_nxt;

  // Scan counters and result
  logic [EW-1:0]  e_cnt_r, e_cnt_nxt;
  logic [RB-1:0]  r_cnt_r, r_cnt_nxt;
  lfha_pkg::rsp_t rsp_r, rsp_nxt;

  // Table and map interfaces
  logic             ent_wr_en;
  logic [15:0]      ent_owner;
  logic             map_wr_en;
  logic [ROW_W-1:0] map_wr_data;
  logic [ROW_W-1:0] map_rd_data;
  logic             clr_busy;
  logic [ROW_W-1:0] row_word;
  logic             row_full;
  logic [CW-1:0]    free_idx;

  // Decisions used by the control blocks
  logic          accept;
  logic          early_reject;
  logic          ent_match;
  logic          ent_free;
  logic [16:0]   h_off;
  logic          h_bad;
  logic [ROW_W-1:0] slot_bit;
  logic [16:0]   handle_sum;

  assign accept   = start && !busy;
  assign busy     = (state_r != lfha_pkg::S_IDLE) || clr_busy;
  assign out_valid = (state_r == lfha_pkg::S_DONE);
  assign out_rsp  = rsp_r;

  assign early_reject = (in_req.operation == lfha_pkg::OP_ALLOC)
                        ? ((in_req.process_id == 16'd0) || (in_req.fs_id == 16'd0))
                        : (in_req.process_id == 16'd0);

  // Offset of the handle from the first handle; a borrow means below range
  assign h_off = {1'b0, in_req.handle} - 17'(FIRST_HANDLE);
  assign h_bad = h_off[16] || (h_off[15:0] >= 16'(SLOTS_PER_PROCESS));

  assign ent_match = (ent_owner == pid_r);
  assign ent_free  = (ent_owner == 16'd0);

  // Padding bits past the last slot count as used
  assign row_word = map_rd_data | ((r_cnt_r == LAST_ROW) ? PAD_MASK : '0);
  assign slot_bit = ROW_W'(1) << slot_r[CW-1:0];
  assign handle_sum = 17'({r_cnt_r, free_idx}) + 17'(FIRST_HANDLE);

  lfha_ent_tbl #(
    .ENT_AW(EW)
  ) u_ent_tbl (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ent_wr_en),
    .wr_addr  (e_cnt_r),
    .wr_owner (pid_r),
    .rd_addr  (e_cnt_nxt),
    .rd_owner (ent_owner)
  );

  lfha_slot_map #(
    .AW   (AW),
    .ROW_W(ROW_W)
  ) u_slot_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (map_wr_en),
    .wr_addr  ({e_cnt_r, r_cnt_r}),
    .wr_data  (map_wr_data),
    .rd_addr  ({e_cnt_nxt, r_cnt_nxt}),
    .rd_data  (map_rd_data),
    .clr_busy (clr_busy)
  );

  lfha_pri_enc #(
    .ROW_W(ROW_W),
    .IDX_W(CW)
  ) u_pri_enc (
    .row  (row_word),
    .full (row_full),
    .idx  (free_idx)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lfha_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = early_reject ? lfha_pkg::S_DONE : lfha_pkg::S_ENTRY;
        end
      end
      lfha_pkg::S_ENTRY: begin
        if (ent_match) begin
          state_nxt = ((op_r == lfha_pkg::OP_RELEASE) && bad_h_r)
                      ? lfha_pkg::S_DONE : lfha_pkg::S_ROW;
        end else if (ent_free) begin
          state_nxt = (op_r == lfha_pkg::OP_ALLOC) ? lfha_pkg::S_ROW : lfha_pkg::S_DONE;
        end else if (e_cnt_r == LAST_ENTRY) begin
          state_nxt = lfha_pkg::S_DONE;
        end
      end
      lfha_pkg::S_ROW: begin
        if ((op_r == lfha_pkg::OP_RELEASE) || !row_full || (r_cnt_r == LAST_ROW)) begin
          state_nxt = lfha_pkg::S_DONE;
        end
      end
      lfha_pkg::S_DONE: begin
        state_nxt = lfha_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lfha_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath control and result
  always_comb begin
    op_nxt      = op_r;
    pid_nxt     = pid_r;
    bad_h_nxt   = bad_h_r;
    slot_nxt    = slot_r;
    e_cnt_nxt   = e_cnt_r;
    r_cnt_nxt   = r_cnt_r;
    rsp_nxt     = rsp_r;
    ent_wr_en   = 1'b0;
    map_wr_en   = 1'b0;
    map_wr_data = map_rd_data;
    unique case (state_r)
      lfha_pkg::S_IDLE: begin
        // Latch the request and start the entry lookup at entry zero
        e_cnt_nxt = '0;
        r_cnt_nxt = '0;
        if (accept) begin
          op_nxt     = in_req.operation;
          pid_nxt    = in_req.process_id;
          bad_h_nxt  = h_bad;
          slot_nxt   = h_off[SW-1:0];
          rsp_nxt.new_handle = 7'd0;
          rsp_nxt.status = (in_req.operation == lfha_pkg::OP_ALLOC)
                           ? lfha_pkg::STATUS_BAD_PARAMS : lfha_pkg::STATUS_NOT_FOUND;
        end
      end
      lfha_pkg::S_ENTRY: begin
        rsp_nxt.new_handle = 7'd0;
        if (ent_match) begin
          // Found: open the first row, or the row that holds the released slot
          rsp_nxt.status = lfha_pkg::STATUS_BAD_PARAMS;
          r_cnt_nxt = (op_r == lfha_pkg::OP_RELEASE) ? RB'(slot_r >> CW) : '0;
        end else if (ent_free) begin
          // Unused entry: claim it on allocate, otherwise the process is unknown
          rsp_nxt.status = lfha_pkg::STATUS_NOT_FOUND;
          ent_wr_en = (op_r == lfha_pkg::OP_ALLOC);
          r_cnt_nxt = '0;
        end else if (e_cnt_r == LAST_ENTRY) begin
          rsp_nxt.status = (op_r == lfha_pkg::OP_ALLOC)
                           ? lfha_pkg::STATUS_FULL : lfha_pkg::STATUS_NOT_FOUND;
        end else begin
          e_cnt_nxt = e_cnt_r + EW'(1);
        end
      end
      lfha_pkg::S_ROW: begin
        if (op_r == lfha_pkg::OP_RELEASE) begin
          // Drop the slot; a free slot stays free
          map_wr_en   = 1'b1;
          map_wr_data = map_rd_data & ~slot_bit;
          rsp_nxt.new_handle = 7'd0;
          rsp_nxt.status     = lfha_pkg::STATUS_OK;
        end else if (!row_full) begin
          // Claim the lowest free slot of this row
          map_wr_en   = 1'b1;
          map_wr_data = map_rd_data | (ROW_W'(1) << free_idx);
          rsp_nxt.new_handle = handle_sum[6:0];
          rsp_nxt.status     = lfha_pkg::STATUS_OK;
        end else if (r_cnt_r == LAST_ROW) begin
          rsp_nxt.new_handle = 7'd0;
          rsp_nxt.status     = lfha_pkg::STATUS_FULL;
        end else begin
          r_cnt_nxt = r_cnt_r + RB'(1);
        end
      end
      lfha_pkg::S_DONE: begin
        e_cnt_nxt = '0;
        r_cnt_nxt = '0;
      end
      default: begin
        e_cnt_nxt = '0;
        r_cnt_nxt = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lfha_pkg::S_IDLE;
      e_cnt_r <= '0;
      r_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      e_cnt_r <= e_cnt_nxt;
      r_cnt_r <= r_cnt_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    pid_r   <= pid_nxt;
    bad_h_r <= bad_h_nxt;
    slot_r  <= slot_nxt;
    rsp_r   <= rsp_nxt;
  end

endmodule

// ----- rtl/lfha_pri_enc.sv -----
// Lowest-zero finder over one occupancy row: the free-slot search unit.
`timescale 1ns / 1ps

module lfha_pri_enc #(
  parameter int ROW_W = 32,
  parameter int IDX_W = 5
) (
  input  logic [ROW_W-1:0] row,
  output logic             full,
  output logic [IDX_W-1:0] idx
);

  // Row has no free bit
  assign full = &row;

  // Pick the lowest clear bit; scan from the top so the lowest wins
  always_comb begin
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (!row[i]) begin
        idx = IDX_W'(i);
      end
    end
  end

endmodule

// ----- rtl/lfha_ent_tbl.sv -----
// Process entry table: owner memory with registered read and per-entry valid bits.
`timescale 1ns / 1ps

module lfha_ent_tbl #(
  parameter int ENT_AW = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ENT_AW-1:0] wr_addr,
  input  logic [15:0]       wr_owner,
  input  logic [ENT_AW-1:0] rd_addr,
  output logic [15:0]       rd_owner
);

  localparam int DEPTH = 2 ** ENT_AW;

  logic [15:0]      owner_mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [15:0]      rd_data_r;
  logic             rd_vld_r;

  // Mark claimed entries; reset frees them all at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // Write owner, read owner registered
  always_ff @(posedge clk) begin
    if (wr_en) begin
      owner_mem[wr_addr] <= wr_owner;
    end
    rd_data_r <= owner_mem[rd_addr];
  end

  // An entry never claimed reads as unused
  assign rd_owner = rd_vld_r ? rd_data_r : 16'd0;

endmodule

// ----- rtl/lfha_slot_map.sv -----
// Slot occupancy map: one bit per slot in rows, registered read, cleared by a sweep after reset.
`timescale 1ns / 1ps

module lfha_slot_map #(
  parameter int AW    = 4,
  parameter int ROW_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [ROW_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [ROW_W-1:0] rd_data,
  output logic             clr_busy
);

  localparam int DEPTH = 2 ** AW;

  logic [ROW_W-1:0] row_mem [DEPTH];
  logic [ROW_W-1:0] rd_data_r;
  logic [AW:0]      clr_cnt_r;
  logic [AW:0]      clr_cnt_nxt;

  // Sweep every row once after reset
  assign clr_busy    = !clr_cnt_r[AW];
  assign clr_cnt_nxt = clr_busy ? clr_cnt_r + (AW + 1)'(1) : clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Clear or update a row, read a row registered
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      row_mem[clr_cnt_r[AW-1:0]] <= '0;
    end else if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= row_mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for the lowest-free handle allocator.
`timescale 1ns / 1ps

module tb;

  localparam int PROCESS_ENTRIES   = lfha_pkg::PROCESS_ENTRIES_DEF;
  localparam int SLOTS_PER_PROCESS = lfha_pkg::SLOTS_PER_PROCESS_DEF;
  localparam int FIRST_HANDLE      = lfha_pkg::FIRST_HANDLE_DEF;
  localparam int RANDOM_REQUESTS   = 1150;
  localparam int CYCLE_LIMIT       = 400000;
  localparam int TAIL_CYCLES       = 20;
  localparam int MAX_PRINTED       = 50;

  // One queued request, or a marker that makes the driver wait for all results
  typedef struct packed {
    logic           drain;
    lfha_pkg::req_t req;
  } pending_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  lfha_pkg::req_t in_req = '0;
  logic busy;
  logic out_valid;
  lfha_pkg::rsp_t out_rsp;

  pending_t       pending_q[$];
  lfha_pkg::rsp_t expected_rsp_q[$];
  logic [15:0]    owner_pid [PROCESS_ENTRIES];

  // Shadow copy of the process table and the slot store
  logic [15:0] model_owner   [PROCESS_ENTRIES];
  logic [15:0] model_slot_fs [PROCESS_ENTRIES][SLOTS_PER_PROCESS];

  int cycle_cnt    = 0;
  int accepted_cnt = 0;
  int result_cnt   = 0;
  int error_cnt    = 0;
  int total_reqs   = 0;
  int status_cnt [4];

  lowest_free_handle_allocator #(
    .PROCESS_ENTRIES  (PROCESS_ENTRIES),
    .SLOTS_PER_PROCESS(SLOTS_PER_PROCESS),
    .FIRST_HANDLE     (FIRST_HANDLE)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // Apply one request to the shadow table and return the answer it must give
  function automatic lfha_pkg::rsp_t predict_handle_result(lfha_pkg::req_t r);
    lfha_pkg::rsp_t res;
    int   e;
    int   s;
    int   hv;
    logic placed;
    res.new_handle = '0;
    res.status     = lfha_pkg::STATUS_OK;
    e = -1;
    if (r.process_id != 16'd0) begin
      for (int i = PROCESS_ENTRIES - 1; i >= 0; i--) begin
        if (model_owner[i] == r.process_id) e = i;
      end
    end
    if (r.operation == lfha_pkg::OP_ALLOC) begin
      if (r.process_id == 16'd0 || r.fs_id == 16'd0) begin
        res.status = lfha_pkg::STATUS_BAD_PARAMS;
      end else begin
        // claim the lowest unused entry for a new process
        if (e < 0) begin
          for (int i = PROCESS_ENTRIES - 1; i >= 0; i--) begin
            if (model_owner[i] == 16'd0) e = i;
          end
          if (e >= 0) model_owner[e] = r.process_id;
        end
        if (e < 0) begin
          res.status = lfha_pkg::STATUS_FULL;
        end else begin
          placed = 1'b0;
          for (s = 0; s < SLOTS_PER_PROCESS; s++) begin
            if (!placed && model_slot_fs[e][s] == 16'd0) begin
              model_slot_fs[e][s] = r.fs_id;
              res.new_handle = 7'(s + FIRST_HANDLE);
              placed = 1'b1;
            end
          end
          if (!placed) res.status = lfha_pkg::STATUS_FULL;
        end
      end
    end else begin
      hv = r.handle;
      if (e < 0) begin
        res.status = lfha_pkg::STATUS_NOT_FOUND;
      end else if (hv < FIRST_HANDLE || hv - FIRST_HANDLE >= SLOTS_PER_PROCESS) begin
        res.status = lfha_pkg::STATUS_BAD_PARAMS;
      end else begin
        model_slot_fs[e][hv - FIRST_HANDLE] = 16'd0;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (error_cnt < MAX_PRINTED) begin
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    end
    error_cnt++;
  endtask

  task automatic queue_request(lfha_pkg::op_t op, logic [15:0] pid, logic [15:0] fs,
                               logic [15:0] h);
    pending_t p;
    p.drain          = 1'b0;
    p.req.operation  = op;
    p.req.process_id = pid;
    p.req.fs_id      = fs;
    p.req.handle     = h;
    pending_q.push_back(p);
    total_reqs++;
  endtask

  task automatic queue_alloc(logic [15:0] pid, logic [15:0] fs);
    queue_request(lfha_pkg::OP_ALLOC, pid, fs, 16'($urandom));
  endtask

  task automatic queue_release(logic [15:0] pid, logic [15:0] h);
    queue_request(lfha_pkg::OP_RELEASE, pid, 16'($urandom), h);
  endtask

  task automatic queue_drain();
    pending_t p;
    p = '0;
    p.drain = 1'b1;
    pending_q.push_back(p);
  endtask

  // Driver: present queued requests, predict each one as it is accepted
  always @(posedge clk) begin
    logic           next_start;
    lfha_pkg::req_t next_req;
    pending_t       p;
    int             idle_pct;
    if (rst_n) begin
      next_start = start;
      next_req   = in_req;
      if (accepted_cnt < total_reqs / 3)           idle_pct = 24;
      else if (accepted_cnt < 2 * total_reqs / 3)  idle_pct = 46;
      else                                         idle_pct = 0;
      if (start && !busy) begin
        expected_rsp_q.push_back(predict_handle_result(in_req));
        accepted_cnt++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        // drop a drain marker once every result is back
        if (pending_q.size() > 0 && pending_q[0].drain && expected_rsp_q.size() == 0) begin
          void'(pending_q.pop_front());
        end
        if (pending_q.size() > 0 && !pending_q[0].drain &&
            $urandom_range(0, 99) >= idle_pct) begin
          p          = pending_q.pop_front();
          next_req   = p.req;
          next_start = 1'b1;
        end
      end
      start  <= next_start;
      in_req <= next_req;
    end
  end

  // Monitor: compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    lfha_pkg::rsp_t want;
    if (rst_n && out_valid) begin
      result_cnt++;
      if (expected_rsp_q.size() == 0) begin
        report_mismatch("result with no request pending", out_rsp.status, -1);
      end else begin
        want = expected_rsp_q.pop_front();
        status_cnt[want.status]++;
        if (out_rsp.new_handle !== want.new_handle) begin
          report_mismatch("new_handle", out_rsp.new_handle, want.new_handle);
        end
        if (out_rsp.status !== want.status) begin
          report_mismatch("status", out_rsp.status, want.status);
        end
      end
    end
  end

  initial begin
    logic [15:0] pid;
    int          n;
    int          s0;
    int          random_cnt;
    int          kind;

    for (int e = 0; e < PROCESS_ENTRIES; e++) begin
      model_owner[e] = 16'd0;
      for (int s = 0; s < SLOTS_PER_PROCESS; s++) model_slot_fs[e][s] = 16'd0;
    end
    for (int i = 0; i < 4; i++) status_cnt[i] = 0;
    owner_pid = '{16'hFFFF, 16'h0001, 16'h8000, 16'h5A5A,
                  16'hA5A5, 16'h7FFF, 16'h00FF, 16'hFF00};

    // Directed: errors on an empty table, first allocations, bounds, full table
    queue_release(16'hFFFF, 16'd3);
    queue_release(16'h0000, 16'd3);
    queue_alloc(16'h0000, 16'd5);
    queue_alloc(16'hFFFF, 16'h0000);
    queue_alloc(16'hFFFF, 16'hFFFF);
    queue_alloc(16'hFFFF, 16'h0001);
    queue_release(16'hFFFF, 16'(FIRST_HANDLE - 1));
    queue_release(16'hFFFF, 16'(FIRST_HANDLE + SLOTS_PER_PROCESS));
    queue_release(16'hFFFF, 16'hFFFF);
    queue_release(16'hFFFF, 16'(FIRST_HANDLE));
    queue_release(16'hFFFF, 16'(FIRST_HANDLE));
    queue_alloc(16'hFFFF, 16'h0007);
    queue_release(16'hFFFF, 16'(FIRST_HANDLE + SLOTS_PER_PROCESS - 1));
    for (int i = 1; i < PROCESS_ENTRIES; i++) queue_alloc(owner_pid[i], 16'(16'h0100 * i + 1));
    queue_alloc(16'h4321, 16'h0042);
    queue_release(16'h4321, 16'd3);
    queue_drain();

    // Random: mostly well-formed traffic on known processes, some noise
    random_cnt = 0;
    n = $urandom_range(64, 70);
    pid = owner_pid[$urandom_range(0, PROCESS_ENTRIES - 1)];
    for (int i = 0; i < n; i++) queue_alloc(pid, 16'($urandom_range(1, 65535)));
    random_cnt += n;
    while (random_cnt < RANDOM_REQUESTS) begin
      kind = $urandom_range(0, 9);
      pid  = owner_pid[$urandom_range(0, PROCESS_ENTRIES - 1)];
      case (kind)
        5: begin
          // long run of allocations on one process, which can run past its last slot
          n = $urandom_range(40, 70);
          for (int i = 0; i < n; i++) queue_alloc(pid, 16'($urandom_range(1, 65535)));
        end
        6: begin
          // sweep releases over a wrapped range of slots
          n  = $urandom_range(8, SLOTS_PER_PROCESS);
          s0 = $urandom_range(0, SLOTS_PER_PROCESS - 1);
          for (int i = 0; i < n; i++) begin
            queue_release(pid, 16'(FIRST_HANDLE + (s0 + i) % SLOTS_PER_PROCESS));
          end
        end
        7: begin
          // fully random fields
          n = 4;
          for (int i = 0; i < n; i++) begin
            queue_request(lfha_pkg::op_t'($urandom_range(0, 1)),
                          ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom),
                          ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom),
                          16'($urandom));
          end
        end
        8: begin
          // malformed requests and unknown processes
          n = 3;
          for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
              0: queue_alloc(16'd0, 16'($urandom_range(1, 65535)));
              1: queue_alloc(pid, 16'd0);
              2: queue_release(pid, 16'($urandom_range(0, FIRST_HANDLE - 1)));
              3: queue_release(pid, 16'($urandom_range(FIRST_HANDLE + SLOTS_PER_PROCESS, 65535)));
              default: begin
                if ($urandom_range(0, 1) == 0) queue_alloc(16'($urandom_range(1, 65535)), 16'd9);
                else queue_release(16'($urandom_range(1, 65535)), 16'(FIRST_HANDLE));
              end
            endcase
          end
        end
        default: begin
          // mixed allocate and release on one process, after a drain for kind 9
          if (kind == 9) queue_drain();
          n = (kind == 9) ? 4 : $urandom_range(8, 24);
          for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 60) begin
              queue_alloc(pid, 16'($urandom_range(1, 65535)));
            end else if ($urandom_range(0, 1) == 0) begin
              queue_release(pid, 16'($urandom_range(FIRST_HANDLE, FIRST_HANDLE + 15)));
            end else begin
              queue_release(pid, 16'($urandom_range(FIRST_HANDLE,
                                                    FIRST_HANDLE + SLOTS_PER_PROCESS - 1)));
            end
          end
        end
      endcase
      random_cnt += n;
    end

    // Hold reset, then release it at a clock edge
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all requests to be taken and all results to come back
    while (!(pending_q.size() == 0 && !start && expected_rsp_q.size() == 0) &&
           cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
    end
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_rsp_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      $display("Ran %0d requests, checked %0d results in %0d cycles, %0d mismatches",
               accepted_cnt, result_cnt, cycle_cnt, error_cnt);
      $display("Outcomes: ok %0d, unknown process %0d, bad parameters %0d, full %0d",
               status_cnt[lfha_pkg::STATUS_OK], status_cnt[lfha_pkg::STATUS_NOT_FOUND],
               status_cnt[lfha_pkg::STATUS_BAD_PARAMS], status_cnt[lfha_pkg::STATUS_FULL]);
      if (error_cnt == 0 && expected_rsp_q.size() == 0) begin
        $display("Verification passed");
      end else begin
        $display("Verification failed");
      end
      $finish;
    end
  end

endmodule
